/* src/slx_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slx_pkg
// Shared types, codes and helper functions of the shell command lexer.
// ----------------------------------------------------------------------------
package slx_pkg;

  localparam int QUOTE_DEPTH = 30;
  localparam int QIDX_W      = 5;
  localparam logic [7:0] TOKEN_LIMIT = 8'd255;
  localparam logic [7:0] TOTAL_MAX   = 8'd255;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_BAR    = 8'h7c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_TWO    = 8'h32;

  // lexer modes
  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_WORD  = 3'd1;
  localparam logic [2:0] M_AMP   = 3'd2;
  localparam logic [2:0] M_BAR   = 3'd3;
  localparam logic [2:0] M_GT    = 3'd4;
  localparam logic [2:0] M_TWO   = 3'd5;
  localparam logic [2:0] M_QUOTE = 3'd6;

  // token kinds
  localparam logic [3:0] K_WORD   = 4'd0;
  localparam logic [3:0] K_PIPE   = 4'd1;
  localparam logic [3:0] K_BG     = 4'd2;
  localparam logic [3:0] K_SEMI   = 4'd3;
  localparam logic [3:0] K_OUT    = 4'd4;
  localparam logic [3:0] K_APPEND = 4'd5;
  localparam logic [3:0] K_IN     = 4'd6;
  localparam logic [3:0] K_ERR    = 4'd7;
  localparam logic [3:0] K_BOTH   = 4'd8;
  localparam logic [3:0] K_AND    = 4'd9;
  localparam logic [3:0] K_OR     = 4'd10;
  localparam logic [3:0] K_END    = 4'd11;

  // datapath operations
  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_LOAD    = 4'd1;
  localparam logic [3:0] OP_STEP_IN = 4'd2;
  localparam logic [3:0] OP_STEP_RP = 4'd3;
  localparam logic [3:0] OP_DRAIN   = 4'd4;
  localparam logic [3:0] OP_TSET    = 4'd5;
  localparam logic [3:0] OP_TLOOP   = 4'd6;
  localparam logic [3:0] OP_TAIL    = 4'd7;
  localparam logic [3:0] OP_TEND    = 4'd8;
  localparam logic [3:0] OP_FLUSH   = 4'd9;

  // outcome of one character step
  localparam logic [1:0] OC_CONSUME = 2'd0;
  localparam logic [1:0] OC_REISSUE = 2'd1;
  localparam logic [1:0] OC_CLOSE   = 2'd2;

  typedef struct packed {
    logic       is_end;
    logic [3:0] kind;
    logic [7:0] ch;
    logic       ovf;
  } res_t;

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] in_byte;
  } cmd_t;

  typedef struct packed {
    logic       slot_ok;
    logic [1:0] outcome;
    logic       drain_done;
    logic       replay_done;
    logic       mode_quote;
    logic       mode_two;
  } sts_t;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'd32, [8'd9:8'd13]};
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return is_space(c) || c inside {CH_AMP, CH_SEMI, CH_BAR, CH_GT, CH_LT};
  endfunction

endpackage

/* src/slx_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slx_datapath
// Lexer state, quote buffer, character step logic and output staging.
// ----------------------------------------------------------------------------
module slx_datapath import slx_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  output sts_t       sts,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_res,
  output logic       out_last
);

  logic [2:0]        mode_r, mode_nxt;
  logic              dbl_r, dbl_nxt;
  logic [QIDX_W-1:0] fill_r, fill_nxt;
  logic              ovf_r, ovf_nxt;
  logic [7:0]        total_r, total_nxt;
  logic              flag_r, flag_nxt;
  logic              rp_r, rp_nxt;    // 1: steps read the quote buffer
  logic [7:0]        c_r, c_nxt;
  logic [QIDX_W-1:0] i_r, i_nxt, j_r, j_nxt, n_r, n_nxt;
  logic [7:0]        store_r [QUOTE_DEPTH];
  logic              hold_v_r, hold_v_nxt;
  res_t              hold_r, hold_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r, out_res_nxt;
  logic              out_last_r, out_last_nxt;

  logic [7:0] sc, q_ch;
  logic       st_em;
  res_t       st_res;
  logic [2:0] st_mode;
  logic [1:0] st_oc;
  logic       st_wr, st_ovf_set, st_open;
  logic       em;
  res_t       em_res;
  logic       wr;
  logic       out_free;

  assign sc   = rp_r ? store_r[i_r] : c_r;
  assign q_ch = dbl_r ? CH_DQUOTE : CH_SQUOTE;

  // one character step: at most one result, the byte is kept or consumed
  always_comb begin
    st_em      = 1'b0;
    st_res     = '0;
    st_mode    = mode_r;
    st_oc      = OC_CONSUME;
    st_wr      = 1'b0;
    st_ovf_set = 1'b0;
    st_open    = 1'b0;
    case (mode_r)
      M_AMP: begin
        st_em = 1'b1; st_res.is_end = 1'b1; st_mode = M_IDLE;
        if (sc == CH_AMP) st_res.kind = K_AND;
        else if (sc == CH_GT) st_res.kind = K_BOTH;
        else begin st_res.kind = K_BG; st_oc = OC_REISSUE; end
      end
      M_BAR: begin
        st_em = 1'b1; st_res.is_end = 1'b1; st_mode = M_IDLE;
        if (sc == CH_BAR) st_res.kind = K_OR;
        else begin st_res.kind = K_PIPE; st_oc = OC_REISSUE; end
      end
      M_GT: begin
        st_em = 1'b1; st_res.is_end = 1'b1; st_mode = M_IDLE;
        if (sc == CH_GT) st_res.kind = K_APPEND;
        else begin st_res.kind = K_OUT; st_oc = OC_REISSUE; end
      end
      M_TWO: begin
        st_em = 1'b1;
        if (sc == CH_GT) begin
          st_res.is_end = 1'b1; st_res.kind = K_ERR; st_mode = M_IDLE;
        end else begin
          st_res.ch = CH_TWO; st_mode = M_WORD; st_oc = OC_REISSUE;
        end
      end
      M_WORD: begin
        st_em = 1'b1;
        if (is_delim(sc)) begin
          st_res.is_end = 1'b1; st_res.kind = K_WORD; st_mode = M_IDLE;
          st_oc = OC_REISSUE;
        end else begin
          st_res.ch = sc;
        end
      end
      M_QUOTE: begin
        if (sc == q_ch) st_oc = OC_CLOSE;
        else if (fill_r < QIDX_W'(QUOTE_DEPTH)) st_wr = 1'b1;
        else st_ovf_set = 1'b1;
      end
      default: begin
        // token start
        st_mode = M_IDLE;
        if (!is_space(sc) && total_r < TOKEN_LIMIT) begin
          case (sc)
            CH_AMP:  st_mode = M_AMP;
            CH_BAR:  st_mode = M_BAR;
            CH_GT:   st_mode = M_GT;
            CH_TWO:  st_mode = M_TWO;
            CH_LT:   begin st_em = 1'b1; st_res.is_end = 1'b1; st_res.kind = K_IN; end
            CH_SEMI: begin st_em = 1'b1; st_res.is_end = 1'b1; st_res.kind = K_SEMI; end
            CH_DQUOTE, CH_SQUOTE: begin st_mode = M_QUOTE; st_open = 1'b1; end
            default: begin st_em = 1'b1; st_res.ch = sc; st_mode = M_WORD; end
          endcase
        end
      end
    endcase
  end

  always_comb begin
    mode_nxt  = mode_r;
    dbl_nxt   = dbl_r;
    fill_nxt  = fill_r;
    ovf_nxt   = ovf_r;
    total_nxt = total_r;
    flag_nxt  = flag_r;
    rp_nxt    = rp_r;
    c_nxt     = c_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    n_nxt     = n_r;
    em        = 1'b0;
    em_res    = '0;
    wr        = 1'b0;
    case (cmd.op)
      OP_LOAD: begin
        c_nxt = cmd.in_byte; rp_nxt = 1'b0;
      end
      OP_STEP_IN, OP_STEP_RP: begin
        em       = st_em;
        em_res   = st_res;
        mode_nxt = st_mode;
        wr       = st_wr;
        if (st_wr) fill_nxt = fill_r + 1'b1;
        if (st_ovf_set) ovf_nxt = 1'b1;
        if (st_open) begin
          dbl_nxt = (sc == CH_DQUOTE); fill_nxt = '0; ovf_nxt = 1'b0;
        end
        if (st_oc == OC_CLOSE) begin
          flag_nxt = ovf_r; j_nxt = '0;
        end
        if (cmd.op == OP_STEP_RP && st_oc != OC_REISSUE) i_nxt = i_r + 1'b1;
      end
      OP_DRAIN: begin
        em = 1'b1;
        if (j_r != fill_r) begin
          em_res.ch = store_r[j_r]; j_nxt = j_r + 1'b1;
        end else begin
          em_res.is_end = 1'b1; em_res.kind = K_WORD;
          flag_nxt = 1'b0; fill_nxt = '0; ovf_nxt = 1'b0; mode_nxt = M_IDLE;
        end
      end
      OP_TSET: flag_nxt = (mode_r == M_QUOTE) ? ovf_r : 1'b0;
      OP_TLOOP: begin
        if (mode_r == M_QUOTE) begin
          em = 1'b1; em_res.ch = q_ch;
          n_nxt = fill_r; i_nxt = '0; fill_nxt = '0; ovf_nxt = 1'b0;
          mode_nxt = M_WORD; rp_nxt = 1'b1;
        end
      end
      OP_TAIL: begin
        em_res.is_end = 1'b1;
        case (mode_r)
          M_AMP:  begin em = 1'b1; em_res.kind = K_BG;   mode_nxt = M_IDLE; end
          M_BAR:  begin em = 1'b1; em_res.kind = K_PIPE; mode_nxt = M_IDLE; end
          M_GT:   begin em = 1'b1; em_res.kind = K_OUT;  mode_nxt = M_IDLE; end
          M_WORD: begin em = 1'b1; em_res.kind = K_WORD; mode_nxt = M_IDLE; end
          M_TWO: begin
            em = 1'b1; em_res.is_end = 1'b0; em_res.ch = CH_TWO; mode_nxt = M_WORD;
          end
          default: em = 1'b0;
        endcase
      end
      OP_TEND: begin
        em = 1'b1; em_res.is_end = 1'b1; em_res.kind = K_END;
        mode_nxt = M_IDLE; dbl_nxt = 1'b0; fill_nxt = '0; ovf_nxt = 1'b0;
        flag_nxt = 1'b0;
      end
      default: em = 1'b0;
    endcase
    em_res.ovf = flag_r;
    if (em && em_res.is_end && em_res.kind != K_END && total_r != TOTAL_MAX)
      total_nxt = total_r + 1'b1;
    if (cmd.op == OP_TEND) total_nxt = '0;
  end

  // output staging: one result held back so the last one can be marked
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    hold_v_nxt    = hold_v_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    out_last_nxt  = out_last_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (hold_v_r && (em || cmd.op == OP_FLUSH)) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = hold_r;
      out_last_nxt  = (cmd.op == OP_FLUSH);
    end
    if (em) begin
      hold_v_nxt = 1'b1; hold_nxt = em_res;
    end else if (cmd.op == OP_FLUSH) begin
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_IDLE;
      dbl_r       <= 1'b0;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      total_r     <= '0;
      flag_r      <= 1'b0;
      rp_r        <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      dbl_r       <= dbl_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      total_r     <= total_nxt;
      flag_r      <= flag_nxt;
      rp_r        <= rp_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r        <= c_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    n_r        <= n_nxt;
    hold_r     <= hold_nxt;
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
    if (wr) store_r[fill_r] <= sc;
  end

  assign sts.slot_ok     = !hold_v_r || out_free;
  assign sts.outcome     = st_oc;
  assign sts.drain_done  = (j_r == fill_r);
  assign sts.replay_done = (i_r == n_r);
  assign sts.mode_quote  = (mode_r == M_QUOTE);
  assign sts.mode_two    = (mode_r == M_TWO);

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_last  = out_last_r;

endmodule

/* src/slx_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slx_controller
// Sequencer: accepts a word, walks the lexer steps, replay and drain.
// ----------------------------------------------------------------------------
module slx_controller import slx_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_is_terminator,
  input  sts_t       sts,
  output cmd_t       cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FEED   = 4'd1;
  localparam logic [3:0] S_DRAIN  = 4'd2;
  localparam logic [3:0] S_TSET   = 4'd3;
  localparam logic [3:0] S_TLOOP  = 4'd4;
  localparam logic [3:0] S_REPLAY = 4'd5;
  localparam logic [3:0] S_TAIL   = 4'd6;
  localparam logic [3:0] S_TEND   = 4'd7;
  localparam logic [3:0] S_FLUSH  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       ret_r, ret_nxt;   // 1: drain returns to replay

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    cmd.op      = OP_NONE;
    cmd.in_byte = in_byte;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = in_is_terminator ? S_TSET : S_FEED;
        end
      end
      S_FEED: begin
        if (sts.slot_ok) begin
          cmd.op = OP_STEP_IN;
          if (sts.outcome == OC_CONSUME) state_nxt = S_FLUSH;
          else if (sts.outcome == OC_CLOSE) begin
            ret_nxt = 1'b0; state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (sts.slot_ok) begin
          cmd.op = OP_DRAIN;
          if (sts.drain_done) state_nxt = ret_r ? S_REPLAY : S_FLUSH;
        end
      end
      S_TSET: begin
        cmd.op    = OP_TSET;
        state_nxt = S_TLOOP;
      end
      S_TLOOP: begin
        if (!sts.mode_quote) state_nxt = S_TAIL;
        else if (sts.slot_ok) begin
          cmd.op = OP_TLOOP; state_nxt = S_REPLAY;
        end
      end
      S_REPLAY: begin
        if (sts.replay_done) state_nxt = S_TLOOP;
        else if (sts.slot_ok) begin
          cmd.op = OP_STEP_RP;
          if (sts.outcome == OC_CLOSE) begin
            ret_nxt = 1'b1; state_nxt = S_DRAIN;
          end
        end
      end
      S_TAIL: begin
        if (sts.slot_ok) begin
          cmd.op = OP_TAIL;
          if (!sts.mode_two) state_nxt = S_TEND;
        end
      end
      S_TEND: begin
        if (sts.slot_ok) begin
          cmd.op = OP_TEND; state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (sts.slot_ok) begin
          cmd.op = OP_FLUSH; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

endmodule

/* src/shell_command_lexer.sv */
`timescale 1ns / 1ps
// Sequence: an ordinary byte is accepted, then takes a lexer step and a flush, plus
//   a step per further result; a closing quote adds a drain step per buffered byte
//   and one for the word marker.
// Flow: a new word is accepted only once the previous one has been flushed; a
//   terminator replays any unclosed quote and then closes what is pending; out_ready
//   stalls hold the steps that make a result.
// Reset: synchronous active-low rst_n clears the sequencer, lexer mode, counts and
//   output valid; the quote buffer is not cleared.
// ----------------------------------------------------------------------------
// shell_command_lexer
// Streaming shell command lexer, one byte per input word, one result per
// output word.
// ----------------------------------------------------------------------------
module shell_command_lexer import slx_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_is_terminator,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_is_token_end,
  output logic [3:0] out_token_kind,
  output logic [7:0] out_char,
  output logic       out_quote_overflow,
  output logic       out_last
);

  // controller issues one datapath operation per cycle, waiting while the output
  // slot is not free; each operation makes at most one result, which sits in a
  // hold stage until the next result or the end of the word decides its last flag
  cmd_t cmd;
  sts_t sts;
  res_t res;

  slx_controller u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_is_terminator (in_is_terminator),
    .sts              (sts),
    .cmd              (cmd)
  );

  slx_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res),
    .out_last  (out_last)
  );

  assign out_is_token_end   = res.is_end;
  assign out_token_kind     = res.kind;
  assign out_char           = res.ch;
  assign out_quote_overflow = res.ovf;

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the shell command lexer: byte words are driven with
// random gaps, a local lexer model predicts every token character and marker,
// and a monitor compares each result word field by field in order.
// ----------------------------------------------------------------------------
module tb;
  import slx_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'd0;
  logic       in_is_terminator = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_is_token_end;
  logic [3:0] out_token_kind;
  logic [7:0] out_char;
  logic       out_quote_overflow;
  logic       out_last;

  typedef struct packed {
    logic       is_end;
    logic [3:0] kind;
    logic [7:0] ch;
    logic       ovf;
    logic       last;
  } lex_res_t;

  lex_res_t token_q[$];   // expected result words, oldest first
  int       err_cnt = 0;
  int       words_sent = 0;
  int       results_seen = 0;
  int       lines_sent = 0;

  // lexer model state
  logic [2:0] lx_mode;
  logic       lx_dq;
  logic [7:0] lx_buf [QUOTE_DEPTH];
  int         lx_fill;
  logic       lx_ovf;
  logic [7:0] lx_total;
  logic       lx_flag;
  lex_res_t   step_res[$];

  shell_command_lexer i_dut (.*);

  always #4 clk = ~clk;

  function automatic logic sp(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic dl(input logic [7:0] c);
    return sp(c) || c == CH_AMP || c == CH_SEMI || c == CH_BAR || c == CH_GT
           || c == CH_LT;
  endfunction

  task automatic put(input logic e, input logic [3:0] k, input logic [7:0] c);
    lex_res_t r;
    if (step_res.size() >= 64) return;
    r.is_end = e; r.kind = k; r.ch = c; r.ovf = lx_flag; r.last = 1'b0;
    step_res.push_back(r);
  endtask

  task automatic mark(input logic [3:0] k);
    put(1'b1, k, 8'd0);
    if (k != K_END && lx_total < TOTAL_MAX) lx_total++;
  endtask

  task automatic begin_token(input logic [7:0] c);
    if (sp(c) || lx_total >= TOKEN_LIMIT) return;
    case (c)
      CH_AMP: lx_mode = M_AMP;
      CH_BAR: lx_mode = M_BAR;
      CH_GT:  lx_mode = M_GT;
      CH_TWO: lx_mode = M_TWO;
      CH_LT:  mark(K_IN);
      CH_SEMI: mark(K_SEMI);
      CH_DQUOTE, CH_SQUOTE: begin
        lx_mode = M_QUOTE; lx_dq = (c == CH_DQUOTE); lx_fill = 0; lx_ovf = 0;
      end
      default: begin
        put(1'b0, K_WORD, c); lx_mode = M_WORD;
      end
    endcase
  endtask

  task automatic in_word(input logic [7:0] c);
    if (dl(c)) begin
      mark(K_WORD); lx_mode = M_IDLE; begin_token(c);
    end else begin
      put(1'b0, K_WORD, c);
    end
  endtask

  task automatic lex_byte(input logic [7:0] c);
    case (lx_mode)
      M_AMP: begin
        lx_mode = M_IDLE;
        if (c == CH_AMP) mark(K_AND);
        else if (c == CH_GT) mark(K_BOTH);
        else begin mark(K_BG); begin_token(c); end
      end
      M_BAR: begin
        lx_mode = M_IDLE;
        if (c == CH_BAR) mark(K_OR);
        else begin mark(K_PIPE); begin_token(c); end
      end
      M_GT: begin
        lx_mode = M_IDLE;
        if (c == CH_GT) mark(K_APPEND);
        else begin mark(K_OUT); begin_token(c); end
      end
      M_TWO: begin
        if (c == CH_GT) begin
          lx_mode = M_IDLE; mark(K_ERR);
        end else begin
          put(1'b0, K_WORD, CH_TWO); lx_mode = M_WORD; in_word(c);
        end
      end
      M_WORD: in_word(c);
      M_QUOTE: begin
        if (c == (lx_dq ? CH_DQUOTE : CH_SQUOTE)) begin
          lx_flag = lx_ovf;
          for (int i = 0; i < lx_fill; i++) put(1'b0, K_WORD, lx_buf[i]);
          mark(K_WORD);
          lx_flag = 0; lx_fill = 0; lx_ovf = 0; lx_mode = M_IDLE;
        end else if (lx_fill < QUOTE_DEPTH) begin
          lx_buf[lx_fill] = c; lx_fill++;
        end else begin
          lx_ovf = 1;
        end
      end
      default: begin
        lx_mode = M_IDLE; begin_token(c);
      end
    endcase
  endtask

  task automatic lexer_clear();
    lx_mode = M_IDLE; lx_dq = 0; lx_fill = 0; lx_ovf = 0; lx_total = 0; lx_flag = 0;
  endtask

  // Terminator: replay any unclosed quote, then close what is pending.
  task automatic end_line();
    logic [7:0] held [QUOTE_DEPTH];
    int n;
    lx_flag = (lx_mode == M_QUOTE) ? lx_ovf : 1'b0;
    while (lx_mode == M_QUOTE) begin
      n = lx_fill;
      for (int i = 0; i < n; i++) held[i] = lx_buf[i];
      lx_fill = 0; lx_ovf = 0;
      put(1'b0, K_WORD, lx_dq ? CH_DQUOTE : CH_SQUOTE);
      lx_mode = M_WORD;
      for (int i = 0; i < n; i++) lex_byte(held[i]);
    end
    case (lx_mode)
      M_AMP: mark(K_BG);
      M_BAR: mark(K_PIPE);
      M_GT: mark(K_OUT);
      M_TWO: begin put(1'b0, K_WORD, CH_TWO); mark(K_WORD); end
      M_WORD: mark(K_WORD);
      default: ;
    endcase
    mark(K_END);
    lexer_clear();
  endtask

  // Queue the results one accepted word causes.
  task automatic predict_word(input logic [7:0] b, input logic t);
    lex_res_t r;
    step_res.delete();
    lx_flag = 0;
    if (t) end_line(); else lex_byte(b);
    if (step_res.size() > 0) begin
      r = step_res[$]; r.last = 1'b1; step_res[$] = r;
    end
    foreach (step_res[i]) token_q.push_back(step_res[i]);
  endtask

  task automatic report(input string what);
    err_cnt++;
    $display("mismatch @%0t: %s", $realtime, what);
  endtask

  // Send one byte word; hold-off first, then valid until accepted.
  // Valid stays up after acceptance; the next word or a drain lowers it.
  task automatic send_word(input logic [7:0] b, input logic t);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1; in_byte <= b; in_is_terminator <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(b, t);
    words_sent++;
    if (t) lines_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    do @(posedge clk); while (token_q.size() != 0);
  endtask

  // Receiver: random stall per result, with calm stretches.
  initial begin
    int st;
    forever begin
      st = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (st > 0) begin
        out_ready <= 1'b0;
        repeat (st) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Result checker
  always @(posedge clk) begin
    lex_res_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (token_q.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        e = token_q.pop_front();
        if (out_is_token_end !== e.is_end) report("is_token_end");
        if (out_token_kind !== e.kind)
          report($sformatf("token_kind got %0d exp %0d", out_token_kind, e.kind));
        if (out_char !== e.ch) report($sformatf("char got %h exp %h", out_char, e.ch));
        if (out_quote_overflow !== e.ovf) report("quote_overflow");
        if (out_last !== e.last) report("last");
      end
    end
  end

  task automatic test_operators();
    send_text("ls -l|wc&&a||b>>c&>d 2>e>f<g;h&i|j 12>k 2");
    send_word(8'd0, 1'b1);
    send_text("x& y> z| 2");
    send_word(8'hff, 1'b1);
  endtask

  task automatic test_odd_bytes();
    send_word(8'h00, 1'b0); send_word(8'hff, 1'b0); send_word(8'h80, 1'b0);
    send_word(8'd9, 1'b0); send_word(8'd13, 1'b0); send_word(8'h7f, 1'b0);
    send_text("a\"b'c");
    send_word(8'h55, 1'b1);
  endtask

  task automatic test_quotes();
    send_text("'it is' \"\" x");
    send_word(8'h00, 1'b1);
    send_text("\"ab;c|d 2>e '");
    send_word(8'h00, 1'b1);
    send_text("'abcdefghijklmnopqrstuvwxyz 0|1>>2");
    send_word(8'h00, 1'b1);
  endtask

  // Sender holds until the lexer has drained everything.
  task automatic test_drain_pause();
    send_text("'q r' ");
    drain_wait();
    send_word(8'h00, 1'b1);
    drain_wait();
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'd32;
      1: return CH_AMP;
      2: return CH_BAR;
      3: return CH_GT;
      4: return CH_TWO;
      5: return ($urandom_range(0, 1)) ? CH_DQUOTE : CH_SQUOTE;
      6: return ($urandom_range(0, 1)) ? CH_SEMI : CH_LT;
      7: return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(8'h61, 8'h7a));
    endcase
  endfunction

  task automatic test_random_lines();
    int sent, len;
    sent = 0;
    while (sent < 20) begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) send_word(pick_byte(), 1'b0);
      send_word(8'($urandom_range(0, 255)), 1'b1);
      sent += len + 1;
    end
  endtask

  initial begin
    int w;
    lexer_clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_operators();
    test_odd_bytes();
    test_quotes();
    test_drain_pause();
    test_random_lines();
    drain_wait();
    w = 0;
    while (token_q.size() == 0 && w < 200) begin @(posedge clk); w++; end
    $display("covered %0d byte words over %0d lines, %0d results checked",
             words_sent, lines_sent, results_seen);
    $display("operators, odd bytes, quoting and overflow replay exercised");
    if (err_cnt == 0 && token_q.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
